@@ hdl/rotated_layer_dither_select_defines.svh @@
// Assertion shorthands used by the checker file of the dither selector.
// Each macro samples on the rising edge of clk and is switched off in reset.
`ifndef ROTATED_LAYER_DITHER_SELECT_DEFINES_SVH
`define ROTATED_LAYER_DITHER_SELECT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RLDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlds check failed in the same cycle");

// Consequent checked in the cycle after the antecedent.
`define RLDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlds check failed one cycle later");

`endif

@@ hdl/rlds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rlds_pkg;

  // Width of one ratio register and of the cycle length (sum of two ratios).
  localparam int RATIO_W     = 8;
  localparam int RATIO_IDX_W = 3;
  localparam int CYC_W       = 9;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_B = 1'b1;

  // Result stream: one flag, padded to a byte.
  localparam int OUT_TDATA_W = 8;

  // (a + b) mod m for a, b below m.
  function automatic logic [CYC_W-1:0] mod_add(input logic [CYC_W-1:0] a,
                                               input logic [CYC_W-1:0] b,
                                               input logic [CYC_W-1:0] m);
    logic [CYC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[CYC_W-1:0];
  endfunction

  // One Horner step of a serial multiply modulo m: (2*acc + en*x) mod m.
  function automatic logic [CYC_W-1:0] mod_dbl_add(input logic [CYC_W-1:0] acc,
                                                   input logic [CYC_W-1:0] x,
                                                   input logic             en,
                                                   input logic [CYC_W-1:0] m);
    logic [CYC_W:0]   d;
    logic [CYC_W-1:0] xx;
    d = {acc, 1'b0};
    if (d >= {1'b0, m}) begin
      d = d - {1'b0, m};
    end
    xx = en ? x : '0;
    return mod_add(d[CYC_W-1:0], xx, m);
  endfunction

endpackage

`default_nettype wire

@@ hdl/rotated_layer_dither_select.sv @@
// Takes one item at a time: the input is ready only while the sequencer is idle.
// Each item runs the bit-serial divider (one quotient bit per cycle) and the 8-step
// modular multiply; both are skipped when a ratio is zero.
// After reset or a ratio write the first item also runs the phase step search (binary gcd,
// one step per cycle, a few candidates); the step found is then cached.
// Reset (rst, synchronous, active high): both ratios return to 1, streams go idle.
`timescale 1ns / 1ps
`default_nettype none

module rotated_layer_dither_select
  import rlds_pkg::*;
#(
  parameter int unsigned RATIO_MAX  = 255,
  parameter int unsigned LAYER_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_wen,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [RATIO_W-1:0]                  cfg_data,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: layer_number [LAYER_BITS-1:0], zero padding above
  input  logic [((LAYER_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: use_b [0], zero padding above
  output logic [OUT_TDATA_W-1:0]              m_axis_tdata
);

  localparam int DIV_BITS = LAYER_BITS - 1;
  localparam int CNT_W    = $clog2(LAYER_BITS);
  localparam logic [RATIO_W-1:0] RMAX =
    (RATIO_MAX >= (1 << RATIO_W)) ? '1 : RATIO_W'(RATIO_MAX);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SINIT = 3'd1;
  localparam logic [2:0] S_SGCD  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIX1  = 3'd4;
  localparam logic [2:0] S_FIX2  = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]          state;
  logic [RATIO_W-1:0]  ratio_a;
  logic [RATIO_W-1:0]  ratio_b;
  logic                step_ok;
  logic [CYC_W-1:0]    step;
  logic [CYC_W-1:0]    cand;
  logic [CYC_W-1:0]    ga;
  logic [CYC_W-1:0]    gb;
  logic [DIV_BITS-1:0] dvd;
  logic [CYC_W-1:0]    rem;
  logic [CYC_W-1:0]    acc;
  logic                neg;
  logic [CYC_W-1:0]    cyc;
  logic [RATIO_W-1:0]  rb_q;
  logic [CNT_W-1:0]    cnt;
  logic [CYC_W-1:0]    pos;
  logic [CYC_W-1:0]    phase;
  logic [CYC_W-1:0]    pval;
  logic                res;
  logic                out_valid;
  logic                out_bit;

  // Saturated ratios and cycle length of the current configuration.
  logic [RATIO_W-1:0]    ra_s;
  logic [RATIO_W-1:0]    rb_s;
  logic [CYC_W-1:0]      c_s;
  assign ra_s = (ratio_a > RMAX) ? RMAX : ratio_a;
  assign rb_s = (ratio_b > RMAX) ? RMAX : ratio_b;
  assign c_s  = {1'b0, ra_s} + {1'b0, rb_s};

  // A negative index n is divided as ~n; quotient and remainder are mapped back later.
  logic [LAYER_BITS-1:0] lay;
  logic                  lay_neg;
  logic [DIV_BITS-1:0]   mag;
  assign lay     = s_axis_tdata[LAYER_BITS-1:0];
  assign lay_neg = lay[LAYER_BITS-1];
  assign mag     = lay_neg ? ~lay[DIV_BITS-1:0] : lay[DIV_BITS-1:0];

  // Restoring division step: one quotient bit per cycle, most significant first.
  logic [CYC_W:0] dtrial;
  logic           qbit;
  logic [CYC_W:0] dnext;
  assign dtrial = {rem, dvd[DIV_BITS-1]};
  assign qbit   = (dtrial >= {1'b0, cyc});
  assign dnext  = qbit ? (dtrial - {1'b0, cyc}) : dtrial;

  // Serial modular multiply of the position by ratio_b, and the final decision.
  logic [CYC_W-1:0] mul_acc;
  logic [CYC_W:0]   dec_sum;
  assign mul_acc = mod_dbl_add(acc, pval, rb_q[cnt[RATIO_IDX_W-1:0]], cyc);
  assign dec_sum = {1'b0, mul_acc} + {2'b0, rb_q};

  // Phase fix-up for negative indices: -(q*s + s) mod c.
  logic [CYC_W-1:0] neg_x;
  assign neg_x = mod_add(acc, step, cyc);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_bit};

  // Configuration registers; a write invalidates the cached phase step.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_a <= RATIO_W'(1);
      ratio_b <= RATIO_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_RATIO_A: ratio_a <= cfg_data;
        REG_RATIO_B: ratio_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: phase step search, division, fix-up, multiply, result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_ok   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The result register empties on its transfer unless a new result replaces it.
      if (out_valid && m_axis_tready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        step_ok <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            dvd  <= mag;
            neg  <= lay_neg;
            rem  <= '0;
            acc  <= '0;
            cyc  <= c_s;
            rb_q <= rb_s;
            cnt  <= CNT_W'(DIV_BITS - 1);
            if (c_s == '0 || rb_s == '0) begin
              res   <= 1'b0;
              state <= S_OUT;
            end else if (ra_s == '0) begin
              res   <= 1'b1;
              state <= S_OUT;
            end else if (step_ok) begin
              state <= S_DIV;
            end else begin
              cand  <= (c_s >> 1) + CYC_W'(1);
              state <= S_SINIT;
            end
          end
        end
        S_SINIT: begin
          // Both even means a common factor of two: skip without running gcd.
          if (!cand[0] && !cyc[0]) begin
            cand <= cand + CYC_W'(1);
          end else begin
            ga    <= cand;
            gb    <= cyc;
            state <= S_SGCD;
          end
        end
        S_SGCD: begin
          if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga == gb) begin
            if (ga == CYC_W'(1)) begin
              step    <= (cand >= cyc) ? (cand - cyc) : cand;
              step_ok <= 1'b1;
              state   <= S_DIV;
            end else begin
              cand  <= cand + CYC_W'(1);
              state <= S_SINIT;
            end
          end else if (ga > gb) begin
            ga <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
        S_DIV: begin
          // Quotient bits feed the phase product (q * step) mod c straight away.
          rem <= dnext[CYC_W-1:0];
          dvd <= dvd << 1;
          acc <= mod_dbl_add(acc, step, qbit, cyc);
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_FIX1;
          end
        end
        S_FIX1: begin
          if (neg) begin
            pos   <= cyc - CYC_W'(1) - rem;
            phase <= (neg_x == '0) ? '0 : (cyc - neg_x);
          end else begin
            pos   <= rem;
            phase <= acc;
          end
          state <= S_FIX2;
        end
        S_FIX2: begin
          pval  <= mod_add(pos, phase, cyc);
          acc   <= '0;
          cnt   <= CNT_W'(RATIO_W - 1);
          state <= S_MUL;
        end
        S_MUL: begin
          acc <= mul_acc;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            // B when (p * rb) mod c + rb reaches c.
            res   <= (dec_sum >= {1'b0, cyc});
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_bit   <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/rlds_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_layer_dither_select_defines.svh"

module rlds_checker
  import rlds_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result stays offered and unchanged.
  `RLDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Only one item is in work at a time: the input closes after a transfer.
  `RLDS_ASSERT_NEXT(a_busy_after_take, in_xfer, !s_axis_tready)

  // With no result waiting, none is offered yet in the cycle after an input transfer.
  `RLDS_ASSERT_NEXT(a_no_instant_result, in_xfer && !m_axis_tvalid, !m_axis_tvalid)

  // The padding above the decision flag is always zero.
  `RLDS_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:1] == '0)

endmodule

bind rotated_layer_dither_select rlds_checker u_rlds_checker (.*);

`default_nettype wire

@@ bench/tb_rotated_layer_dither_select.sv @@
`timescale 1ns / 1ps

module tb_rotated_layer_dither_select;
  import rlds_pkg::*;

  localparam int LAYER_W     = 24;
  localparam int IN_TDATA_W  = ((LAYER_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_WAIT = LAYER_W + 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_RATIO_A;
  logic [RATIO_W-1:0]     cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Bench copy of the two ratio registers, kept in step with every write.
  logic [RATIO_W-1:0]     ratio_a_copy = 8'd1;
  logic [RATIO_W-1:0]     ratio_b_copy = 8'd1;

  logic [LAYER_W-1:0]     layer_backlog[$];
  bit                     use_b_expected[$];
  int                     items_pending = 0;
  int                     error_count = 0;
  int                     cycle_count = 0;

  rotated_layer_dither_select #(
    .RATIO_MAX (255),
    .LAYER_BITS(LAYER_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random idling on either side, switched off in a quiet window of the run.
  function automatic bit idle_now();
    if (cycle_count >= 20000 && cycle_count < 35000) begin
      return 1'b0;
    end
    return ($urandom_range(0, 99) < 12);
  endfunction

  // Expected selection for one layer index under the given ratios. The ratio
  // registers are 8 bits wide, so saturation at the ratio limit never bites.
  function automatic bit predict_use_b(input logic [RATIO_W-1:0] ra,
                                       input logic [RATIO_W-1:0] rb,
                                       input logic [LAYER_W-1:0] layer);
    longint n, c, pos, k, step, phase, p, ga, gb, gt;
    n = $signed(layer);
    c = longint'(ra) + longint'(rb);
    if (c == 0 || rb == 0) begin
      return 1'b0;
    end
    if (ra == 0) begin
      return 1'b1;
    end
    // Phase step: first value from c/2+1 upward that is coprime with c.
    step = c / 2 + 1;
    forever begin
      ga = step;
      gb = c;
      while (gb != 0) begin
        gt = ga % gb;
        ga = gb;
        gb = gt;
      end
      if (ga == 1) begin
        break;
      end
      step++;
    end
    step = step % c;
    // Floor modulo and floor division keep the cycles continuous below zero.
    pos = n % c;
    if (pos < 0) begin
      pos = pos + c;
    end
    k = (n - pos) / c;
    phase = (k * step) % c;
    if (phase < 0) begin
      phase = phase + c;
    end
    p = (pos + phase) % c;
    return (((p + 1) * rb) / c) > ((p * rb) / c);
  endfunction

  // Driver: records the expectation for each accepted transfer, then offers
  // the next layer index from the backlog.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        use_b_expected = {use_b_expected,
                          predict_use_b(ratio_a_copy, ratio_b_copy,
                                        s_axis_tdata[LAYER_W-1:0])};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (layer_backlog.size() != 0 && !idle_now()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= layer_backlog.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    m_axis_tready <= !idle_now();
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (use_b_expected.size() == 0) begin
        $error("unexpected result transfer: use_b actual %0b", m_axis_tdata[0]);
        error_count++;
      end else begin
        if (m_axis_tdata[0] !== use_b_expected[0]) begin
          $error("use_b mismatch: expected %0b actual %0b", use_b_expected[0],
                 m_axis_tdata[0]);
          error_count++;
        end
        void'(use_b_expected.pop_front());
        items_pending--;
      end
    end
  end

  task automatic queue_layer(input longint value);
    logic [63:0] raw;
    raw = value;
    layer_backlog = {layer_backlog, raw[LAYER_W-1:0]};
    items_pending++;
  endtask

  // Wait until every queued item has produced its result, plus some margin.
  task automatic settle();
    while (items_pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [CFG_IDX_W-1:0] idx,
                             input logic [RATIO_W-1:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    if (idx == REG_RATIO_A) begin
      ratio_a_copy = value;
    end else begin
      ratio_b_copy = value;
    end
  endtask

  task automatic set_ratios(input logic [RATIO_W-1:0] ra, input logic [RATIO_W-1:0] rb);
    settle();
    write_ratio(REG_RATIO_A, ra);
    write_ratio(REG_RATIO_B, rb);
  endtask

  // Mix of indices near zero, across the whole range, at the range ends and
  // right at cycle boundaries.
  function automatic longint random_layer(input longint c);
    longint v;
    if (c == 0) begin
      c = 1;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = longint'($urandom_range(0, 6 * c + 6)) - (3 * c + 3);
      4, 5, 6:    v = $signed($urandom() & 32'h00FF_FFFF);
      7: begin
        if ($urandom_range(0, 1) == 1) begin
          v = 8388607 - longint'($urandom_range(0, 600));
        end else begin
          v = -8388608 + longint'($urandom_range(0, 600));
        end
      end
      default: v = (longint'($urandom_range(0, 32000)) - 16000) * c
                   + longint'($urandom_range(0, 2)) - 1;
    endcase
    return v;
  endfunction

  function automatic logic [RATIO_W-1:0] random_ratio();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return 8'($urandom_range(2, 16));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      queue_layer(random_layer(longint'(ratio_a_copy) + longint'(ratio_b_copy)));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [RATIO_W-1:0] fixed_a[9];
    logic [RATIO_W-1:0] fixed_b[9];
    fixed_a = '{8'd0, 8'd0, 8'd9, 8'd255, 8'd255, 8'd1, 8'd0, 8'd255, 8'd2};
    fixed_b = '{8'd0, 8'd7, 8'd0, 8'd255, 8'd1, 8'd255, 8'd255, 8'd0, 8'd3};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset ratios: zero, small indices of both signs, the range ends and their neighbours.
    queue_layer(0);
    queue_layer(1);
    queue_layer(-1);
    queue_layer(2);
    queue_layer(-2);
    queue_layer(3);
    queue_layer(-3);
    queue_layer(8388607);
    queue_layer(-8388608);
    queue_layer(8388606);
    queue_layer(-8388607);

    // Uneven ratio: indices around cycle boundaries on both sides of zero.
    set_ratios(8'd3, 8'd5);
    for (int v = -9; v <= 9; v += 3) begin
      queue_layer(v);
      queue_layer(v - 1);
    end

    // Fixed settings: empty cycle, no A, no B, both maximal, lopsided and a small uneven pair.
    for (int i = 0; i < 9; i++) begin
      set_ratios(fixed_a[i], fixed_b[i]);
      queue_random(40);
    end

    // Random settings.
    for (int i = 0; i < 12; i++) begin
      set_ratios(random_ratio(), random_ratio());
      queue_random(75);
    end

    settle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
